### rtl/core/srbd_pkg.sv
package srbd_pkg;

   localparam int unsigned MAX_RUNS   = 1024;
   localparam int unsigned RUNS_W     = $clog2(MAX_RUNS + 1);
   localparam int unsigned INDEX_W    = $clog2(MAX_RUNS);
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [8:0] MASS_MAX = 9'd511;

   // register indexes on the csr port
   localparam logic [1:0] CSR_MIN_RUN_LENGTH = 2'd0;
   localparam logic [1:0] CSR_END_MISS_LIMIT = 2'd1;
   localparam logic [1:0] CSR_FILL_TENTHS    = 2'd2;

   localparam logic [7:0] MIN_RUN_LENGTH_RST = 8'd3;
   localparam logic [3:0] END_MISS_LIMIT_RST = 4'd5;
   localparam logic [3:0] FILL_TENTHS_RST    = 4'd7;

   // result kinds
   localparam logic KIND_RUN     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic       is_target;
      logic [7:0] column;
      logic [7:0] row;
      logic       end_of_row;
      logic       end_of_frame;
   } srbd_req_type;

   typedef struct packed {
      logic               kind;
      logic [7:0]         line;
      logic [7:0]         run_start;
      logic [7:0]         run_end;
      logic [7:0]         run_length;
      logic [INDEX_W-1:0] run_index;
      logic [INDEX_W-1:0] band_top;
      logic [INDEX_W-1:0] band_bottom;
      logic [RUNS_W-1:0]  band_runs;
      logic               found;
      logic               overflow;
      logic               last;
   } srbd_rsp_type;

   typedef struct packed {
      logic [7:0]         line;
      logic [7:0]         run_start;
      logic [7:0]         run_end;
      logic [7:0]         run_length;
      logic [INDEX_W-1:0] run_index;
   } srbd_widest_type;

   typedef struct packed {
      logic [RUNS_W-1:0]  count;
      logic [INDEX_W-1:0] top;
      logic [INDEX_W-1:0] bottom;
   } srbd_band_type;

endpackage

### rtl/core/scanline_run_band_detector_core.sv
// An item is held in the input register, and its results are then queued for output.
// Throughput: one item per cycle while at most two results wait in the four-entry
// result queue, else the input stalls; a frame-end item that stores a run yields two.
// Reset (synchronous, active high): all run and band state cleared, the queue
// emptied, registers back to min_run_length 3, end_miss_limit 5, fill_tenths 7.
module scanline_run_band_detector_core
   import srbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  srbd_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output srbd_rsp_type rsp_payload,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   // configuration
   logic [7:0] min_run_length_ff;
   logic [3:0] end_miss_limit_ff;
   logic [3:0] fill_tenths_ff;

   // input stage
   logic         in_valid_ff, in_valid_in;
   srbd_req_type in_ff;
   logic         req_accept, advance;

   // run and band state
   logic            in_run_ff, in_run_in;
   logic [4:0]      hit_ff, hit_in;
   logic [8:0]      mass_ff, mass_in;
   logic [7:0]      cur_start_ff, cur_start_in;
   logic [7:0]      cur_end_ff, cur_end_in;
   logic            row_has_run_ff, row_has_run_in;
   logic            in_band_ff, in_band_in;
   srbd_band_type   band_ff, band_in;
   srbd_band_type   best_ff, best_in;
   logic [RUNS_W-1:0] runs_seen_ff, runs_seen_in;
   srbd_widest_type widest_ff, widest_in;
   logic            dropped_ff, dropped_in;

   // result queue
   srbd_rsp_type          fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic                  pop;
   logic [1:0]            npush;
   srbd_rsp_type          res_first, res_second;

   // per-item working values
   logic            eor, eof;
   logic            in_run_m, close_miss;
   logic [4:0]      hit_m, hit_inc;
   logic [8:0]      mass_m, mass_inc;
   logic [7:0]      start_m, end_m, len_m;
   logic            judge_en, qualify, full, store, drop;
   logic [12:0]     mass_x10;
   logic [11:0]     len_fill;
   logic            row_has_j, in_band_j;
   srbd_band_type   band_j, band_e, best_e, best_f;
   logic            in_band_e;
   logic [RUNS_W-1:0] runs_j;
   srbd_widest_type widest_j;
   logic            dropped_j, any_run;
   srbd_rsp_type    rec, summary;

   // ---------------- handshake ----------------
   assign advance     = in_valid_ff && (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign req_stall   = in_valid_ff && !advance;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = fifo_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;

   // ---------------- run tracking ----------------
   assign eof = in_ff.end_of_frame;
   assign eor = in_ff.end_of_row || in_ff.end_of_frame;

   always_comb begin
      hit_inc    = hit_ff + 5'd1;
      mass_inc   = (mass_ff < MASS_MAX) ? mass_ff + 9'd1 : mass_ff;
      in_run_m   = in_run_ff;
      hit_m      = hit_ff;
      mass_m     = mass_ff;
      start_m    = cur_start_ff;
      end_m      = cur_end_ff;
      close_miss = 1'b0;
      if (in_run_ff) begin
         if (!in_ff.is_target) begin
            hit_m = hit_inc;
            // misses need not be consecutive
            if (hit_inc > {1'b0, end_miss_limit_ff}) begin
               close_miss = 1'b1;
               in_run_m   = 1'b0;
               hit_m      = '0;
            end
         end else begin
            end_m  = in_ff.column;
            mass_m = mass_inc;
         end
      end else if (in_ff.is_target) begin
         hit_m  = hit_inc;
         mass_m = mass_inc;
         // arm on the second target pixel since the counter was cleared
         if (hit_inc > 5'd1) begin
            in_run_m = 1'b1;
            hit_m    = '0;
            end_m    = in_ff.column;
            start_m  = (in_ff.column != 8'd0) ? in_ff.column - 8'd1 : 8'd0;
         end
      end
   end

   // ---------------- judging ----------------
   always_comb begin
      judge_en = close_miss || (eor && in_run_m);
      len_m    = (end_m >= start_m) ? end_m - start_m : 8'd0;
      mass_x10 = {1'b0, mass_m, 3'b000} + {3'b000, mass_m, 1'b0};
      len_fill = {4'b0000, len_m} * {8'h00, fill_tenths_ff};
      qualify  = judge_en && (len_m > min_run_length_ff) && (mass_x10 > {1'b0, len_fill});
      full     = (runs_seen_ff >= RUNS_W'(MAX_RUNS));
      store    = qualify && !full;
      drop     = qualify && full;
   end

   // ---------------- band and widest ----------------
   always_comb begin
      row_has_j = row_has_run_ff || store;
      in_band_j = in_band_ff || store;
      band_j    = band_ff;
      widest_j  = widest_ff;
      runs_j    = runs_seen_ff;
      dropped_j = dropped_ff || drop;
      if (store) begin
         if (!in_band_ff) begin
            band_j.top = runs_seen_ff[INDEX_W-1:0];
         end
         band_j.bottom = runs_seen_ff[INDEX_W-1:0];
         band_j.count  = band_ff.count + RUNS_W'(1);
         runs_j        = runs_seen_ff + RUNS_W'(1);
         // replace only on a strictly longer run
         if ((runs_seen_ff == '0) || (widest_ff.run_length < len_m)) begin
            widest_j.line       = in_ff.row;
            widest_j.run_start  = start_m;
            widest_j.run_end    = end_m;
            widest_j.run_length = len_m;
            widest_j.run_index  = runs_seen_ff[INDEX_W-1:0];
         end
      end

      // a row without a run ends the current band
      best_e    = best_ff;
      band_e    = band_j;
      in_band_e = in_band_j;
      if (eor && !row_has_j) begin
         if (band_j.count > best_ff.count) begin
            best_e = band_j;
         end
         in_band_e    = 1'b0;
         band_e.count = '0;
      end

      best_f = best_e;
      if (band_e.count > best_e.count) begin
         best_f = band_e;
      end
   end

   // ---------------- results ----------------
   always_comb begin
      any_run = (runs_j != '0);

      rec             = '0;
      rec.kind        = KIND_RUN;
      rec.line        = in_ff.row;
      rec.run_start   = start_m;
      rec.run_end     = end_m;
      rec.run_length  = len_m;
      rec.run_index   = runs_seen_ff[INDEX_W-1:0];
      rec.found       = 1'b1;
      rec.overflow    = dropped_ff;
      rec.last        = !eof;

      summary             = '0;
      summary.kind        = KIND_SUMMARY;
      if (any_run) begin
         summary.line       = widest_j.line;
         summary.run_start  = widest_j.run_start;
         summary.run_end    = widest_j.run_end;
         summary.run_length = widest_j.run_length;
         summary.run_index  = widest_j.run_index;
      end
      summary.band_top    = best_f.top;
      summary.band_bottom = best_f.bottom;
      summary.band_runs   = best_f.count;
      summary.found       = any_run;
      summary.overflow    = dropped_j;
      summary.last        = 1'b1;

      res_first  = store ? rec : summary;
      res_second = summary;
      npush      = '0;
      if (advance) begin
         npush = {1'b0, store} + {1'b0, eof};
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      in_run_in      = in_run_ff;
      hit_in         = hit_ff;
      mass_in        = mass_ff;
      cur_start_in   = cur_start_ff;
      cur_end_in     = cur_end_ff;
      row_has_run_in = row_has_run_ff;
      in_band_in     = in_band_ff;
      band_in        = band_ff;
      best_in        = best_ff;
      runs_seen_in   = runs_seen_ff;
      widest_in      = widest_ff;
      dropped_in     = dropped_ff;
      if (advance) begin
         if (eof) begin
            // frame done: clear everything
            in_run_in      = 1'b0;
            hit_in         = '0;
            mass_in        = '0;
            cur_start_in   = '0;
            cur_end_in     = '0;
            row_has_run_in = 1'b0;
            in_band_in     = 1'b0;
            band_in        = '0;
            best_in        = '0;
            runs_seen_in   = '0;
            widest_in      = '0;
            dropped_in     = 1'b0;
         end else begin
            cur_start_in = start_m;
            cur_end_in   = end_m;
            runs_seen_in = runs_j;
            widest_in    = widest_j;
            dropped_in   = dropped_j;
            best_in      = best_e;
            band_in      = band_e;
            in_band_in   = in_band_e;
            if (eor) begin
               in_run_in      = 1'b0;
               hit_in         = '0;
               mass_in        = '0;
               row_has_run_in = 1'b0;
            end else begin
               in_run_in      = in_run_m;
               hit_in         = hit_m;
               mass_in        = close_miss ? 9'd0 : mass_m;
               row_has_run_in = row_has_j;
            end
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_length_ff <= MIN_RUN_LENGTH_RST;
         end_miss_limit_ff <= END_MISS_LIMIT_RST;
         fill_tenths_ff    <= FILL_TENTHS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_RUN_LENGTH: min_run_length_ff <= csr_wdata;
            CSR_END_MISS_LIMIT: end_miss_limit_ff <= csr_wdata[3:0];
            CSR_FILL_TENTHS:    fill_tenths_ff    <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         in_run_ff      <= 1'b0;
         hit_ff         <= '0;
         mass_ff        <= '0;
         cur_start_ff   <= '0;
         cur_end_ff     <= '0;
         row_has_run_ff <= 1'b0;
         in_band_ff     <= 1'b0;
         band_ff        <= '0;
         best_ff        <= '0;
         runs_seen_ff   <= '0;
         widest_ff      <= '0;
         dropped_ff     <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         in_run_ff      <= in_run_in;
         hit_ff         <= hit_in;
         mass_ff        <= mass_in;
         cur_start_ff   <= cur_start_in;
         cur_end_ff     <= cur_end_in;
         row_has_run_ff <= row_has_run_in;
         in_band_ff     <= in_band_in;
         band_ff        <= band_in;
         best_ff        <= best_in;
         runs_seen_ff   <= runs_seen_in;
         widest_ff      <= widest_in;
         dropped_ff     <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (npush != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res_first;
      end
      if (npush == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= res_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(npush);
         rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(pop);
         count_ff  <= count_ff + FIFO_CNT_W'(npush) - FIFO_CNT_W'(pop);
      end
   end

`ifndef SYNTHESIS
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_frame_clear : assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.end_of_frame |=> (runs_seen_ff == '0) && !in_run_ff && !dropped_ff)
      else $error("state not cleared after frame end");

   a_band_le_runs : assert property (@(posedge clock) disable iff (reset)
      best_ff.count <= runs_seen_ff && band_ff.count <= runs_seen_ff)
      else $error("band longer than stored runs");

   a_summary_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == KIND_SUMMARY) |-> rsp_payload.last)
      else $error("summary not marked last");
`endif

endmodule
